### rtl/wrt_pkg.sv
// shared types and constants of the windowed rate throttler
// used by every module under rtl; depends on nothing else
package wrt_pkg;

  // defaults of the top-level parameters
  localparam int unsigned RING_DEPTH_DEF  = 256;
  localparam int unsigned STALE_LIMIT_DEF = 1000000;

  // batch cap in whole packets and in Q14.16
  localparam int unsigned BATCH_CAP   = 10000;
  localparam int unsigned BATCH_W     = 30;
  localparam logic [BATCH_W-1:0] BATCH_ONE = BATCH_W'(65536);
  localparam logic [31:0] BATCH_CAP_Q = 32'(BATCH_CAP) << 16;
  localparam logic [31:0] SHRINK_Q16  = 32'd65470;
  localparam logic [31:0] GROW_Q16    = 32'd65864;

  // rate limit register, unsigned Q32.8
  localparam int unsigned RATE_LIMIT_W = 40;
  localparam logic [RATE_LIMIT_W-1:0] RATE_LIMIT_RST = RATE_LIMIT_W'(256000);

  // apb register map: 64-bit registers at 8-byte spacing
  localparam int unsigned APB_ADDR_W  = 4;
  localparam int unsigned APB_DATA_W  = 64;
  localparam int unsigned REG_IDX_LSB = 3;
  localparam logic [APB_ADDR_W-REG_IDX_LSB-1:0] REG_RATE_LIMIT = '0;

  // arithmetic constants
  localparam int unsigned USEC_W       = 20;   // width of one million
  localparam logic [31:0] USEC_PER_SEC = 32'd1000000;
  localparam int unsigned WAIT_W       = 17;
  localparam logic [31:0] WAIT_SCALE   = 32'd100000;
  localparam logic [WAIT_W-1:0] WAIT_MAX = WAIT_W'(100000);

  // shared multiplier: wide operand by one 32-bit operand, chunk by chunk
  localparam int unsigned MUL_A_W = 96;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned MUL_P_W = 128;

  // shared divider: quotient bits and step counter
  localparam int unsigned DIV_Q_W    = 32;
  localparam int unsigned DIV_STEP_W = 6;

  typedef enum logic [1:0] {
    ACT_SEND  = 2'd0,
    ACT_WAIT  = 2'd1,
    ACT_STALE = 2'd2
  } action_e;

  typedef struct packed {
    logic [63:0] now_us;
    logic [63:0] sent_total;
  } in_item_t;

  typedef struct packed {
    action_e     action;
    logic [13:0] batch_count;
    logic [16:0] wait_us;
    logic [31:0] measured_rate;
  } out_item_t;

endpackage

### rtl/wrt_ring.sv
// ring memory of time and packet-count samples, one write and one read port
// read data registered; depends on wrt_pkg
module wrt_ring import wrt_pkg::*; #(
  parameter int unsigned DEPTH  = RING_DEPTH_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  in_item_t          wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output in_item_t          rdata_o
);

  in_item_t mem [DEPTH];
  in_item_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/wrt_mul.sv
// iterative multiplier: 96-bit operand times 32-bit operand into 128 bits
// one 32x32 product per cycle, accumulated msb chunk first; depends on wrt_pkg
module wrt_mul import wrt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic               busy_o,
  output logic [MUL_P_W-1:0] prod_o
);

  localparam int unsigned NCH    = MUL_A_W / MUL_B_W;
  localparam int unsigned STEP_W = $clog2(NCH + 1);

  logic [MUL_A_W-1:0]   a_q;
  logic [MUL_B_W-1:0]   b_q;
  logic [2*MUL_B_W-1:0] part_q;
  logic [MUL_P_W-1:0]   acc_q;
  logic                 part_vld_q;
  logic [STEP_W-1:0]    step_q;
  logic                 busy_q;

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      step_q     <= '0;
      part_vld_q <= 1'b0;
    end else if (start_i) begin
      busy_q     <= 1'b1;
      step_q     <= '0;
      part_vld_q <= 1'b0;
    end else if (busy_q) begin
      part_vld_q <= (step_q < STEP_W'(NCH));
      step_q     <= step_q + 1'b1;
      if (step_q == STEP_W'(NCH)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // partial product, then shift-and-add into the accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (step_q < STEP_W'(NCH)) begin
        part_q <= a_q[MUL_A_W-1 -: MUL_B_W] * b_q;
        a_q    <= a_q << MUL_B_W;
      end
      if (part_vld_q) begin
        acc_q <= (acc_q << MUL_B_W) + MUL_P_W'(part_q);
      end
    end
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;

endmodule

### rtl/wrt_div.sv
// restoring divider, one quotient bit per cycle
// caller supplies the partial remainder below the divisor; depends on wrt_pkg
module wrt_div import wrt_pkg::*; #(
  parameter int unsigned REM_W = 60
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [REM_W-1:0]      rem_i,
  input  logic [DIV_Q_W-1:0]    num_i,
  input  logic [REM_W-1:0]      den_i,
  input  logic [DIV_STEP_W-1:0] steps_i,
  output logic                  busy_o,
  output logic [DIV_Q_W-1:0]    quo_o
);

  logic [REM_W-1:0]      rem_q;
  logic [DIV_Q_W-1:0]    num_q;
  logic [REM_W-1:0]      den_q;
  logic [DIV_Q_W-1:0]    quo_q;
  logic [DIV_STEP_W-1:0] cnt_q;
  logic                  busy_q;

  logic [REM_W:0] trial;
  logic [REM_W:0] diff;
  logic           ge;

  // one trial subtraction
  always_comb begin
    trial = {rem_q, num_q[DIV_Q_W-1]};
    ge    = (trial >= {1'b0, den_q});
    diff  = trial - {1'b0, den_q};
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= (steps_i != '0);
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DIV_STEP_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      num_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      num_q <= num_q << 1;
      quo_q <= {quo_q[DIV_Q_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

### rtl/windowed_rate_throttler.sv
// windowed rate throttler: sliding-window packet rate limiter, adaptive batch
// top level with sequencer, apb register and result register
// depends on wrt_pkg, wrt_ring, wrt_mul and wrt_div
// usage
//   in channel: one attempt transaction carries the current time in us and
//   the running packet total. it is stored in the sample ring and compared
//   with the sample taken RING_DEPTH - 1 attempts earlier.
//   out channel: one result transaction per attempt: send with a batch
//   size, wait with a pause in us, or stale window. apb port: rate_limit at
//   byte address 0; the user writes it only while idle, the block does not check.
// sequencing
//   one attempt at a time, accept to next accept: a stale window ends after
//   the stale test; a grant or capped wait also runs the rate division (skipped
//   when the rate saturates), and a divided wait adds the wait division; the
//   products come from the chunked 32x32 multiplier.
//   a new attempt is taken while the previous result waits in the output
//   register; a result is held until the receiver takes it.
// reset
//   the ring reads as all zeros until each entry is written (fill marker, no
//   clearing pass), batch returns to 1.0 and rate_limit to 1000 packets/s.
module windowed_rate_throttler import wrt_pkg::*; #(
  parameter int unsigned RING_DEPTH     = RING_DEPTH_DEF,
  parameter int unsigned STALE_LIMIT_US = STALE_LIMIT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // attempt channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned DT_W  = $clog2(STALE_LIMIT_US + 1);
  localparam int unsigned B_W   = DT_W + RATE_LIMIT_W;    // dt * rate_limit
  localparam int unsigned N1_W  = 64 + USEC_W;            // dp * 1e6
  localparam int unsigned A_W   = N1_W + 8;               // dp * 256e6
  localparam int unsigned M_W   = B_W + WAIT_W;           // excess * 1e5
  localparam int unsigned HI_W  = N1_W - DIV_Q_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_MUL_N,
    S_MUL_B,
    S_CMP,
    S_MUL_E,
    S_RATE,
    S_DIV_W,
    S_BATCH,
    S_MUL_BATCH,
    S_FIN
  } state_e;

  state_e                  state_q;
  logic [PTR_W-1:0]        ptr_q;
  logic                    full_q;
  logic                    old_vld_q;
  in_item_t                in_q;
  logic [RATE_LIMIT_W-1:0] rl_q;
  logic [BATCH_W-1:0]      batch_q;
  logic [DT_W-1:0]         dt_q;
  logic [N1_W-1:0]         n1_q;
  logic                    sat_q;
  logic [B_W-1:0]          b_q;
  logic                    fast_q;
  logic                    wmax_q;
  logic [31:0]             rate_q;
  logic [WAIT_W-1:0]       wait_q;
  out_item_t               res_q;
  out_item_t               out_q;
  logic                    out_valid_q;

  // ring access
  logic             in_acc;
  logic             ptr_last;
  logic [PTR_W-1:0] ptr_nxt;
  in_item_t         ring_rdata;

  // window differences
  in_item_t    old_s;
  logic [63:0] dt_full;
  logic [63:0] dp_full;
  logic        stale;

  // shared units
  logic               mul_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_busy;
  logic [MUL_P_W-1:0] mul_prod;
  logic                  div_start;
  logic [B_W-1:0]        div_rem;
  logic [DIV_Q_W-1:0]    div_num;
  logic [B_W-1:0]        div_den;
  logic [DIV_STEP_W-1:0] div_steps;
  logic                  div_busy;
  logic [DIV_Q_W-1:0]    div_quo;

  // rate compare and excess
  logic             n1_sat;
  logic [A_W-1:0]   a_w;
  logic [A_W-1:0]   b_ext;
  logic [A_W-1:0]   excess;
  logic             fast;
  logic             wmax;
  logic [M_W-1:0]   m_val;

  // batch update
  logic [47:0]        bprod;
  logic [BATCH_W-1:0] shrunk;
  logic [47:0]        gsum;
  logic [31:0]        grown;
  logic [BATCH_W-1:0] grown_cap;

  // configuration decode
  logic [APB_ADDR_W-REG_IDX_LSB-1:0] reg_idx;
  logic                              cfg_we;

  assign reg_idx = paddr[APB_ADDR_W-1:REG_IDX_LSB];
  assign cfg_we  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_RATE_LIMIT) ? APB_DATA_W'(rl_q) : '0;

  // ring pointer and memory
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign ptr_last   = (ptr_q == PTR_W'(RING_DEPTH - 1));
  assign ptr_nxt    = ptr_last ? '0 : ptr_q + 1'b1;

  wrt_ring #(
    .DEPTH  (RING_DEPTH),
    .ADDR_W (PTR_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (ptr_q),
    .wdata_i (in_data_i),
    .raddr_i (ptr_nxt),
    .rdata_o (ring_rdata)
  );

  // oldest sample and window differences
  always_comb begin
    old_s   = old_vld_q ? ring_rdata : '0;
    dt_full = in_q.now_us - old_s.now_us;
    dp_full = in_q.sent_total - old_s.sent_total;
    stale   = (dt_full > 64'(STALE_LIMIT_US));
  end

  // rate saturates when the high part of dp*1e6 reaches dt (covers dt of zero)
  assign n1_sat = (mul_prod[N1_W-1:DIV_Q_W] >= HI_W'(dt_q));

  // too-fast test and excess over the limit
  always_comb begin
    a_w    = {n1_q, 8'b0};
    b_ext  = A_W'(b_q);
    fast   = (a_w > b_ext);
    excess = a_w - b_ext;
    wmax   = (b_q == '0) || (excess >= b_ext);
    m_val  = mul_prod[M_W-1:0];
  end

  // batch shrink and grow
  always_comb begin
    bprod     = mul_prod[47:0];
    shrunk    = bprod[BATCH_W+15:16];
    gsum      = bprod + 48'hFFFF;
    grown     = gsum[47:16];
    grown_cap = (grown > BATCH_CAP_Q) ? BATCH_CAP_Q[BATCH_W-1:0] : grown[BATCH_W-1:0];
    if (shrunk == '0) begin
      shrunk = BATCH_W'(1);
    end
  end

  // operand selection for the shared multiplier and divider
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_rem   = '0;
    div_num   = '0;
    div_den   = '0;
    div_steps = '0;
    case (state_q)
      S_READ: begin
        mul_start = ~stale;
        mul_a     = MUL_A_W'(dp_full);
        mul_b     = USEC_PER_SEC;
      end
      S_MUL_N: begin
        mul_start = ~mul_busy;
        mul_a     = MUL_A_W'(rl_q);
        mul_b     = MUL_B_W'(dt_q);
        div_start = ~mul_busy & ~n1_sat;
        div_rem   = B_W'(mul_prod[DIV_Q_W +: DT_W]);
        div_num   = mul_prod[DIV_Q_W-1:0];
        div_den   = B_W'(dt_q);
        div_steps = DIV_STEP_W'(DIV_Q_W);
      end
      S_CMP: begin
        mul_start = fast & ~wmax;
        mul_a     = MUL_A_W'(excess[B_W-1:0]);
        mul_b     = WAIT_SCALE;
      end
      S_RATE: begin
        div_start = ~div_busy & fast_q & ~wmax_q;
        div_rem   = m_val[M_W-1:WAIT_W];
        div_num   = {m_val[WAIT_W-1:0], (DIV_Q_W - WAIT_W)'(0)};
        div_den   = b_q;
        div_steps = DIV_STEP_W'(WAIT_W);
      end
      S_BATCH: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(batch_q);
        mul_b     = fast_q ? SHRINK_Q16 : GROW_Q16;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  wrt_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .prod_o  (mul_prod)
  );

  wrt_div #(
    .REM_W (B_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (div_rem),
    .num_i   (div_num),
    .den_i   (div_den),
    .steps_i (div_steps),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  // sequencer with its registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      full_q      <= 1'b0;
      old_vld_q   <= 1'b0;
      in_q        <= '0;
      rl_q        <= RATE_LIMIT_RST;
      batch_q     <= BATCH_ONE;
      dt_q        <= '0;
      n1_q        <= '0;
      sat_q       <= 1'b0;
      b_q         <= '0;
      fast_q      <= 1'b0;
      wmax_q      <= 1'b0;
      rate_q      <= '0;
      wait_q      <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // configuration write
      if (cfg_we && reg_idx == REG_RATE_LIMIT) begin
        rl_q <= pwdata[RATE_LIMIT_W-1:0];
      end

      // result register drains on the receiver side; a finishing result reloads it
      if (out_valid_q && out_ready_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        // store the sample, advance the pointer, fetch the oldest entry
        S_IDLE: begin
          if (in_acc) begin
            in_q      <= in_data_i;
            ptr_q     <= ptr_nxt;
            old_vld_q <= full_q | ptr_last;
            full_q    <= full_q | ptr_last;
            state_q   <= S_READ;
          end
        end
        // stale test, start dp * 1e6
        S_READ: begin
          if (stale) begin
            batch_q <= BATCH_ONE;
            res_q   <= '{action: ACT_STALE, batch_count: '0, wait_us: '0,
                         measured_rate: '0};
            state_q <= S_FIN;
          end else begin
            dt_q    <= dt_full[DT_W-1:0];
            state_q <= S_MUL_N;
          end
        end
        // dp * 1e6 done: start dt * rate_limit and any unsaturated rate division
        S_MUL_N: begin
          if (!mul_busy) begin
            n1_q    <= mul_prod[N1_W-1:0];
            sat_q   <= n1_sat;
            state_q <= S_MUL_B;
          end
        end
        S_MUL_B: begin
          if (!mul_busy) begin
            b_q     <= mul_prod[B_W-1:0];
            state_q <= S_CMP;
          end
        end
        // too-fast decision, start excess * 1e5 when a division is needed
        S_CMP: begin
          fast_q  <= fast;
          wmax_q  <= wmax;
          state_q <= (fast && !wmax) ? S_MUL_E : S_RATE;
        end
        S_MUL_E: begin
          if (!mul_busy) begin
            state_q <= S_RATE;
          end
        end
        // collect the rate, start the wait division when needed
        S_RATE: begin
          if (!div_busy) begin
            rate_q <= sat_q ? '1 : div_quo;
            wait_q <= fast_q ? WAIT_MAX : '0;
            state_q <= (fast_q && !wmax_q) ? S_DIV_W : S_BATCH;
          end
        end
        S_DIV_W: begin
          if (!div_busy) begin
            wait_q  <= (div_quo > DIV_Q_W'(WAIT_MAX)) ? WAIT_MAX : div_quo[WAIT_W-1:0];
            state_q <= S_BATCH;
          end
        end
        S_BATCH: begin
          state_q <= S_MUL_BATCH;
        end
        // apply the batch factor and build the result
        S_MUL_BATCH: begin
          if (!mul_busy) begin
            if (fast_q) begin
              batch_q <= shrunk;
              res_q   <= '{action: ACT_WAIT, batch_count: '0, wait_us: wait_q,
                           measured_rate: rate_q};
            end else begin
              batch_q <= grown_cap;
              res_q   <= '{action: ACT_SEND, batch_count: grown_cap[BATCH_W-1:16],
                           wait_us: '0, measured_rate: rate_q};
            end
            state_q <= S_FIN;
          end
        end
        // hand over to the output register once it is free
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### tb/sv/windowed_rate_throttler_tb.sv
// testbench for the windowed rate throttler: directed and random attempts,
// rate limit changes over apb, results checked against a cycle-free predictor
// depends on wrt_pkg and the windowed_rate_throttler rtl
module windowed_rate_throttler_tb;
  import wrt_pkg::*;

  localparam int unsigned CLK_HALF      = 4;
  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 215;
  localparam int unsigned MAX_GAP       = 16;
  localparam int unsigned SHOWN_ERRORS  = 10;

  localparam logic [APB_ADDR_W-REG_IDX_LSB-1:0] REG_UNMAPPED = REG_RATE_LIMIT + 1'b1;
  localparam logic [RATE_LIMIT_W-1:0] LIMIT_MAX  = '1;
  // packets per second scaled to the q.8 limit: dp * 256e6 against dt * limit
  localparam logic [127:0] LIMIT_SCALE = 128'd256000000;
  // traffic generator divisor: 256 * 1e6 us * 100 percent
  localparam logic [63:0]  TRAFFIC_DIV = 64'd25600000000;

  // mirror of the throttler state and queue of predicted verdicts
  class throttle_scoreboard;
    logic [63:0]             stamp_ring [RING_DEPTH_DEF];
    logic [63:0]             count_ring [RING_DEPTH_DEF];
    int unsigned             slot;
    logic [BATCH_W-1:0]      batch_q16;
    logic [RATE_LIMIT_W-1:0] limit_q8;
    out_item_t               verdicts_due [$];
    int unsigned             mismatches;

    function new();
      foreach (stamp_ring[i]) begin
        stamp_ring[i] = '0;
        count_ring[i] = '0;
      end
      slot       = 0;
      batch_q16  = BATCH_ONE;
      limit_q8   = RATE_LIMIT_RST;
      mismatches = 0;
    endfunction

    function void apply_write(logic [APB_ADDR_W-REG_IDX_LSB-1:0] idx, logic [63:0] data);
      // only the rate limit exists, upper bits are dropped
      if (idx == REG_RATE_LIMIT) limit_q8 = data[RATE_LIMIT_W-1:0];
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= SHOWN_ERRORS) $display("%s", what);
    endfunction

    // one attempt: store the sample, compare with the oldest, adapt the batch
    function out_item_t judge(in_item_t t);
      logic [63:0]  dt;
      logic [63:0]  dp;
      logic [63:0]  nb;
      logic [127:0] ask;
      logic [127:0] allow;
      logic [127:0] excess;
      logic [127:0] quo;
      out_item_t    r;
      stamp_ring[slot] = t.now_us;
      count_ring[slot] = t.sent_total;
      slot = (slot + 1) % RING_DEPTH_DEF;
      dt = t.now_us - stamp_ring[slot];
      dp = t.sent_total - count_ring[slot];
      r = '0;

      // stale window restarts the batch
      if (dt > 64'(STALE_LIMIT_DEF)) begin
        batch_q16 = BATCH_ONE;
        r.action  = ACT_STALE;
        return r;
      end

      // measured rate, saturated; zero window time saturates
      if (dt == 0) begin
        r.measured_rate = '1;
      end else begin
        quo = (128'(dp) * 128'(USEC_PER_SEC)) / 128'(dt);
        r.measured_rate = (quo > 128'hFFFF_FFFF) ? '1 : quo[31:0];
      end

      ask   = 128'(dp) * LIMIT_SCALE;
      allow = 128'(dt) * 128'(limit_q8);
      if (ask > allow) begin
        // too fast: wait in proportion to the excess, capped; zero allowance caps too
        excess = ask - allow;
        if (excess >= allow) begin
          r.wait_us = WAIT_MAX;
        end else begin
          quo = (excess * 128'(WAIT_SCALE)) / allow;
          r.wait_us = (quo > 128'(WAIT_MAX)) ? WAIT_MAX : quo[WAIT_W-1:0];
        end
        nb = (64'(batch_q16) * 64'(SHRINK_Q16)) >> 16;
        batch_q16 = (nb == 0) ? BATCH_W'(1) : nb[BATCH_W-1:0];
        r.action  = ACT_WAIT;
      end else begin
        // grant: grow rounding up, then cap
        nb = (64'(batch_q16) * 64'(GROW_Q16) + 64'hFFFF) >> 16;
        if (nb > 64'(BATCH_CAP_Q)) nb = 64'(BATCH_CAP_Q);
        batch_q16     = nb[BATCH_W-1:0];
        r.action      = ACT_SEND;
        r.batch_count = batch_q16[BATCH_W-1:16];
      end
      return r;
    endfunction

    function void note_attempt(in_item_t t);
      verdicts_due.push_back(judge(t));
    endfunction

    function void check_verdict(out_item_t got);
      out_item_t want;
      if (verdicts_due.size() == 0) begin
        flag($sformatf("unexpected result: act=%0d batch=%0d wait=%0d rate=%0d",
                       got.action, got.batch_count, got.wait_us, got.measured_rate));
        return;
      end
      want = verdicts_due.pop_front();
      if (got.action !== want.action || got.batch_count !== want.batch_count ||
          got.wait_us !== want.wait_us || got.measured_rate !== want.measured_rate)
        flag($sformatf({"result mismatch: expected act=%0d batch=%0d wait=%0d rate=%0d, ",
                        "got act=%0d batch=%0d wait=%0d rate=%0d"},
                       want.action, want.batch_count, want.wait_us, want.measured_rate,
                       got.action, got.batch_count, got.wait_us, got.measured_rate));
    endfunction

    function void check_readback(logic [APB_DATA_W-1:0] got);
      if (got !== APB_DATA_W'(limit_q8))
        flag($sformatf("rate_limit readback: expected %0h, got %0h", limit_q8, got));
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_data_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  throttle_scoreboard sb;
  bit                 tx_gaps     = 1'b1;
  bit                 rx_stalls   = 1'b1;
  int unsigned        cycle_count = 0;

  windowed_rate_throttler u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // clock
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // transaction monitors on both channels
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_attempt(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_verdict(out_data_o);
  end

  // result sink with random stalls before each transaction when rx_stalls is set
  initial begin : result_sink
    int unsigned stall;
    forever begin
      stall = rx_stalls ? $urandom_range(0, MAX_GAP) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // valid stays high across back-to-back transactions
  task automatic send_attempt(input logic [63:0] now, input logic [63:0] total);
    int unsigned gap;
    in_item_t    item;
    gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
    item.now_us     = now;
    item.sent_total = total;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // hold off the sender until every verdict is back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.verdicts_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-REG_IDX_LSB-1:0] idx,
                           input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx) << REG_IDX_LSB;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.apply_write(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_limit_readback();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_ADDR_W'(REG_RATE_LIMIT) << REG_IDX_LSB;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.check_readback(prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [RATE_LIMIT_W-1:0] phase_limit(int unsigned ph);
    logic [RATE_LIMIT_W-1:0] v;
    v = RATE_LIMIT_W'(rand64());
    if (v == 0) v = RATE_LIMIT_W'(1);
    case (ph)
      0, 6:    return RATE_LIMIT_RST;
      1:       return RATE_LIMIT_W'(1);
      2:       return LIMIT_MAX;
      4:       return '0;
      5:       return RATE_LIMIT_W'($urandom_range(256, 25600000));
      default: return v;
    endcase
  endfunction

  // stimulus
  initial begin
    logic [63:0]             clock_us;
    logic [63:0]             sent;
    logic [63:0]             step;
    logic [63:0]             inc;
    logic [63:0]             wdata;
    logic [RATE_LIMIT_W-1:0] limit;
    int unsigned             factor;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: ring still zero, default limit of 1000 packets/s
    send_attempt(64'd0, 64'd0);          // zero window time, nothing sent
    send_attempt(64'd0, 64'd7);          // zero window time with traffic
    send_attempt(64'd1000000, 64'd1000); // exactly at limit, window at the stale edge
    send_attempt(64'd1000000, 64'd1500); // half over the limit, divided wait
    send_attempt(64'd1000001, 64'd0);    // just stale
    send_attempt('1, '1);                // all ones
    send_attempt(64'd500000, '1);        // huge count, saturated rate
    send_attempt(64'd999999, 64'd0);     // idle window
    wait_idle();

    // unmapped register is ignored, then zero limit
    apb_write(REG_UNMAPPED, '1);
    check_limit_readback();
    apb_write(REG_RATE_LIMIT, '0);
    check_limit_readback();
    send_attempt(64'd10, 64'd0);
    send_attempt(64'd10, 64'd1);
    wait_idle();

    // largest limit, bits above the register dropped
    apb_write(REG_RATE_LIMIT, '1);
    check_limit_readback();
    send_attempt(64'd1000, 64'd1000000);
    send_attempt(64'd1, 64'hFFFF_FFFF);
    wait_idle();

    // smallest limit
    apb_write(REG_RATE_LIMIT, 64'd1);
    check_limit_readback();
    send_attempt(64'd1000000, 64'd1);
    send_attempt(64'd1000000, 64'd0);

    // random phases: steady traffic around the limit, some noise
    clock_us = '0;
    sent     = '0;
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      limit = phase_limit(ph);
      wdata = rand64();
      wdata[RATE_LIMIT_W-1:0] = limit;
      apb_write(REG_RATE_LIMIT, wdata);
      check_limit_readback();
      tx_gaps   = (ph % 3) != 2;
      rx_stalls = (ph % 4) != 1;
      // count runs across the 64-bit wrap under heavy traffic
      if (limit == LIMIT_MAX) sent = 64'hFFFF_FFFF_C000_0000;
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 3) begin
          send_attempt(rand64(), rand64());
        end else begin
          // odd phases keep the window close to one second
          step   = (ph % 2 != 0) ? 64'($urandom_range(0, 7800))
                                 : 64'($urandom_range(0, 2000));
          factor = $urandom_range(40, 260);
          if (limit == 0)
            inc = ($urandom_range(0, 15) == 0) ? 64'd1 : 64'd0;
          else
            inc = (step * limit * factor + rand64() % TRAFFIC_DIV) / TRAFFIC_DIV;
          clock_us = clock_us + step;
          sent     = sent + inc;
          send_attempt(clock_us, sent);
        end
      end
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.verdicts_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
